@@ sv/awss_pkg.sv @@
package awss_pkg;

    // Configuration register map.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [15:0] PERIOD_RST     = 16'd500;
    localparam logic [6:0]  DUTY_RST       = 7'd50;
    localparam logic [7:0]  BRIGHTNESS_RST = 8'd255;
    localparam logic [6:0]  LED_COUNT_RST  = 7'd64;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int PIX_W   = 6;
    localparam int CHAN_W  = 8;
    localparam int COUNT_W = 7;
    localparam int PROD_W  = 23;   // period times percent
    localparam int INTV_W  = 16;

    localparam int MAX_LEDS_DEF = 64;

    // Percent scale and flash step range.
    localparam logic [6:0] PCT_FULL        = 7'd100;
    localparam logic [2:0] FLASH_STEP_LAST = 3'd5;
    localparam logic [2:0] FLASH_STEP_SWAP = 3'd3;

    // Division by 100 as multiplication by floor(2^30/100), one correction step.
    localparam logic [23:0] RECIP_100   = 24'd10737418;
    localparam int          RECIP_100_SH = 30;

    // Amber green channel: 191*b/255, the division done as (y*32897) >> 23.
    localparam logic [7:0]  AMBER_NUM   = 8'd191;
    localparam logic [16:0] RECIP_255   = 17'd32897;
    localparam int          RECIP_255_SH = 23;

    typedef struct packed {
        logic [15:0] period_ms;
        logic [6:0]  duty_percent;
        logic [7:0]  brightness;
        logic [6:0]  led_count;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RECIP,
        S_REM,
        S_INTV,
        S_CMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic recip;
        logic rem;
        logic intv;
        logic start;
        logic next;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic toggle;
        logic last;
    } t_dp_status;

endpackage

@@ sv/awss_time_if.sv @@
interface awss_time_if import awss_pkg::*;;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

@@ sv/awss_pixel_if.sv @@
interface awss_pixel_if import awss_pkg::*;;
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  pixel_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] white;
    logic              last_pixel;

    modport source (
        output valid, output pixel_index, output red, output green,
        output blue, output white, output last_pixel, input ready
    );
    modport sink (
        input valid, input pixel_index, input red, input green,
        input blue, input white, input last_pixel, output ready
    );
endinterface

@@ sv/awss_cfg_regs.sv @@
module awss_cfg_regs import awss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register file; each write keeps the low bits that the register holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_ms    <= PERIOD_RST;
            r_cfg.duty_percent <= DUTY_RST;
            r_cfg.brightness   <= BRIGHTNESS_RST;
            r_cfg.led_count    <= LED_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PERIOD:     r_cfg.period_ms    <= i_cfg_data;
                REG_DUTY:       r_cfg.duty_percent <= i_cfg_data[6:0];
                REG_BRIGHTNESS: r_cfg.brightness   <= i_cfg_data[7:0];
                REG_LED_COUNT:  r_cfg.led_count    <= i_cfg_data[6:0];
                default:        r_cfg              <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/awss_ctrl.sv @@
module awss_ctrl import awss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: interval arithmetic in four steps, then the frame if the flash toggles.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_RECIP;
            end
            S_RECIP: n_state = S_REM;
            S_REM:   n_state = S_INTV;
            S_INTV:  n_state = S_CMP;
            S_CMP: begin
                n_state = i_status.toggle ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_out_ready && i_status.last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: handshake and datapath commands.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_RECIP: o_cmd.recip = 1'b1;
            S_REM:   o_cmd.rem   = 1'b1;
            S_INTV:  o_cmd.intv  = 1'b1;
            S_CMP: begin
                o_cmd.start = i_status.toggle;
            end
            S_EMIT: begin
                o_out_valid  = 1'b1;
                o_cmd.next   = i_out_ready && !i_status.last;
                o_cmd.finish = i_out_ready && i_status.last;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a frame is being sent");

    a_emit_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_CMP)
        else $error("frame started without a toggle decision");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == S_IDLE)
        else $error("controller did not return to idle after the last pixel");
`endif

endmodule

@@ sv/awss_datapath.sv @@
module awss_datapath import awss_pkg::*; #(
    parameter int MAX_LEDS = MAX_LEDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_ctrl_cmd         i_cmd,
    input  logic [TIME_W-1:0] i_now_ms,
    output t_dp_status        o_status,
    output logic [PIX_W-1:0]  o_pixel_index,
    output logic [CHAN_W-1:0] o_red,
    output logic [CHAN_W-1:0] o_green,
    output logic [CHAN_W-1:0] o_blue,
    output logic [CHAN_W-1:0] o_white,
    output logic              o_last_pixel
);

    // Sequencer state.
    logic [TIME_W-1:0]  r_last;
    logic               r_lit;
    logic [2:0]         r_step;

    // Interval pipeline registers.
    logic [TIME_W-1:0]  r_now;
    logic [PROD_W-1:0]  r_x;
    logic [15:0]        r_y;
    logic [INTV_W-1:0]  r_q0;
    logic [CHAN_W-1:0]  r_g;
    logic [7:0]         r_rem;
    logic [INTV_W-1:0]  r_intv;
    logic [TIME_W-1:0]  r_elapsed;

    // Frame registers.
    logic [COUNT_W-1:0] r_n;
    logic [PIX_W-1:0]   r_pix;
    logic               r_swapped;

    logic [6:0]         duty_sat;
    logic [6:0]         pct_sel;
    logic [46:0]        recip_prod;
    logic [32:0]        green_prod;
    logic [PROD_W-1:0]  q0_times_100;
    logic [COUNT_W-1:0] n_clamped;
    logic [COUNT_W-1:0] half;
    logic [COUNT_W-1:0] mid;
    logic [COUNT_W-1:0] pix_ext;
    logic               left;
    logic               dark;

    // Percent that applies: on share while lit, off share while dark.
    assign duty_sat = (i_cfg.duty_percent > PCT_FULL) ? PCT_FULL : i_cfg.duty_percent;
    assign pct_sel  = r_lit ? duty_sat : PCT_FULL - duty_sat;

    assign recip_prod   = 47'(r_x) * 47'(RECIP_100);
    assign green_prod   = 33'(r_y) * 33'(RECIP_255);
    assign q0_times_100 = PROD_W'(r_q0) * PROD_W'(PCT_FULL);

    // LED count clamp to 1..MAX_LEDS.
    always_comb begin
        priority if (i_cfg.led_count == '0) begin
            n_clamped = COUNT_W'(1);
        end else if (i_cfg.led_count > COUNT_W'(MAX_LEDS)) begin
            n_clamped = COUNT_W'(MAX_LEDS);
        end else begin
            n_clamped = i_cfg.led_count;
        end
    end

    // Interval arithmetic: product, reciprocal estimate, remainder, correction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= i_now_ms;
            r_x   <= PROD_W'(i_cfg.period_ms) * PROD_W'(pct_sel);
            r_y   <= 16'(i_cfg.brightness) * 16'(AMBER_NUM);
        end
        if (i_cmd.recip) begin
            r_q0 <= recip_prod[RECIP_100_SH +: INTV_W];
            r_g  <= green_prod[RECIP_255_SH +: CHAN_W];
        end
        if (i_cmd.rem) begin
            r_rem <= 8'(r_x - q0_times_100);
        end
        if (i_cmd.intv) begin
            r_intv    <= r_q0 + INTV_W'(r_rem >= 8'(PCT_FULL));
            r_elapsed <= r_now - r_last;
        end
    end

    assign o_status.toggle = r_elapsed >= TIME_W'(r_intv);

    // Toggle state and flash step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_lit  <= 1'b0;
            r_step <= '0;
        end else begin
            if (i_cmd.start) begin
                r_last <= r_now;
                r_lit  <= !r_lit;
            end
            if (i_cmd.finish && r_lit) begin
                r_step <= (r_step >= FLASH_STEP_LAST) ? 3'd0 : r_step + 3'd1;
            end
        end
    end

    // Frame latch and pixel counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n       <= n_clamped;
            r_swapped <= r_step >= FLASH_STEP_SWAP;
            r_pix     <= '0;
        end else if (i_cmd.next) begin
            r_pix <= r_pix + PIX_W'(1);
        end
    end

    // Pixel colour from its position in the frame.
    assign pix_ext       = COUNT_W'(r_pix);
    assign half          = (r_n + COUNT_W'(1)) >> 1;
    assign mid           = r_n >> 1;
    assign left          = pix_ext < half;
    assign dark          = !r_lit || (r_n[0] && pix_ext == mid);
    assign o_status.last = pix_ext == r_n - COUNT_W'(1);

    always_comb begin
        o_pixel_index = r_pix;
        o_last_pixel  = o_status.last;
        o_red         = '0;
        o_green       = '0;
        o_blue        = '0;
        o_white       = '0;
        priority if (dark) begin
            o_red = '0;
        end else if (left != r_swapped) begin
            o_red   = i_cfg.brightness;
            o_green = r_g;
        end else begin
            o_white = i_cfg.brightness;
        end
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= FLASH_STEP_LAST)
        else $error("flash step out of range");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> (r_n != '0 && r_n <= COUNT_W'(MAX_LEDS) && r_pix == '0))
        else $error("frame latched with a bad LED count");

    a_lit_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> r_lit != $past(r_lit))
        else $error("flash flag did not toggle");
`endif

endmodule

@@ sv/amber_white_strobe_sequencer.sv @@
// Amber/white strobe sequencer.
// Input channel i_time carries the current millisecond time, one transfer per
// tick. The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) sets period,
// duty, brightness and LED count; write it only while the block is idle.
// When the on or off interval has elapsed the block toggles the flash and
// sends one RGBW pixel per LED on o_pixel, in index order, with last_pixel set
// on the final one so that the strip can refresh.
// Each time transfer goes through interval arithmetic (product, reciprocal
// multiply, remainder, correction, compare). With no toggle the block is ready
// again once the compare is done; with a toggle the first pixel is valid after
// the compare and the frame then sends one pixel per cycle while o_pixel is
// ready. The pixel counter is the loop that sets that pace. No time transfer is
// taken while a frame is out. A stall on o_pixel holds the current pixel and
// the counter until it is taken. Synchronous reset restores the register
// defaults (500 ms, 50 %, brightness 255, 64 LEDs), clears the toggle time,
// turns the flash off and returns the flash step to zero.
module amber_white_strobe_sequencer import awss_pkg::*; #(
    parameter int MAX_LEDS = MAX_LEDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    awss_time_if.sink             i_time,
    awss_pixel_if.source          o_pixel
);

    t_cfg       cfg;
    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Configuration registers.
    awss_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Sequencing of the arithmetic steps and the pixel transfers.
    awss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_time.valid),
        .i_out_ready (o_pixel.ready),
        .i_status    (status),
        .o_in_ready  (i_time.ready),
        .o_out_valid (o_pixel.valid),
        .o_cmd       (cmd)
    );

    // Interval arithmetic, flash state and pixel colours.
    awss_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .i_now_ms      (i_time.now_ms),
        .o_status      (status),
        .o_pixel_index (o_pixel.pixel_index),
        .o_red         (o_pixel.red),
        .o_green       (o_pixel.green),
        .o_blue        (o_pixel.blue),
        .o_white       (o_pixel.white),
        .o_last_pixel  (o_pixel.last_pixel)
    );

endmodule

@@ tb/sv/tb_amber_white_strobe_sequencer.sv @@
module tb_amber_white_strobe_sequencer;
    import awss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_GAP     = 17;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 12;
    localparam int DRAIN_LIMIT = 200000;

    // One pixel as it appears on the output channel.
    typedef struct packed {
        logic [PIX_W-1:0]  pix_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] white;
        logic              last_pixel;
    } t_pixel;

    // Tracks the strobe state and the pixels still owed by the block.
    class frame_scoreboard;
        logic [15:0]       period_ms;
        logic [6:0]        duty_pct;
        logic [7:0]        bright;
        logic [6:0]        led_cnt;
        logic [TIME_W-1:0] last_toggle;
        bit                lit;
        logic [2:0]        step;
        t_pixel            owed_pixels[$];
        int                errors;

        function new();
            period_ms   = PERIOD_RST;
            duty_pct    = DUTY_RST;
            bright      = BRIGHTNESS_RST;
            led_cnt     = LED_COUNT_RST;
            last_toggle = '0;
            lit         = 1'b0;
            step        = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PERIOD:     period_ms = data[15:0];
                REG_DUTY:       duty_pct  = data[6:0];
                REG_BRIGHTNESS: bright    = data[7:0];
                REG_LED_COUNT:  led_cnt   = data[6:0];
                default: ;
            endcase
        endfunction

        // Interval that applies in the current on/off state.
        function int unsigned interval_ms();
            int unsigned d;
            int unsigned on_iv;
            int unsigned off_iv;
            d      = (duty_pct > PCT_FULL) ? PCT_FULL : duty_pct;
            on_iv  = (int'(period_ms) * d) / 100;
            off_iv = (int'(period_ms) * (100 - d)) / 100;
            return lit ? on_iv : off_iv;
        endfunction

        function int pending();
            return owed_pixels.size();
        endfunction

        // Works out the frame, if any, caused by one accepted time transfer.
        function void note_time(logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] elapsed;
            int unsigned       n;
            int unsigned       half;
            logic [7:0]        amber_g;
            bit                odd;
            bit                swapped;
            bit                left;
            t_pixel            p;
            elapsed = now - last_toggle;
            if (elapsed < interval_ms()) return;
            last_toggle = now;
            lit         = !lit;
            n = led_cnt;
            if (n == 0) n = 1;
            if (n > MAX_LEDS_DEF) n = MAX_LEDS_DEF;
            half    = (n + 1) / 2;
            odd     = n[0];
            amber_g = 8'((191 * int'(bright)) / 255);
            swapped = (step >= FLASH_STEP_SWAP);
            for (int unsigned i = 0; i < n; i++) begin
                p            = '0;
                p.pix_index  = i[PIX_W-1:0];
                p.last_pixel = (i + 1 == n);
                left         = (i < half);
                if (!lit || (odd && i == n / 2)) begin
                    // Dark pixel: all channels stay zero.
                end else if (left != swapped) begin
                    p.red   = bright;
                    p.green = amber_g;
                end else begin
                    p.white = bright;
                end
                owed_pixels.push_back(p);
            end
            if (lit) step = (step >= FLASH_STEP_LAST) ? 3'd0 : step + 3'd1;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) $display("ERROR at %0t: %s", $realtime, msg);
        endtask

        // Compares one received pixel with the oldest owed one.
        task check_pixel(t_pixel got);
            t_pixel want;
            if (owed_pixels.size() == 0) begin
                report($sformatf("unexpected pixel %0d", got.pix_index));
                return;
            end
            want = owed_pixels.pop_front();
            if (got.pix_index !== want.pix_index)
                report($sformatf("pixel_index got %0d want %0d",
                                 got.pix_index, want.pix_index));
            if (got.red !== want.red)
                report($sformatf("pixel %0d red got %0d want %0d",
                                 want.pix_index, got.red, want.red));
            if (got.green !== want.green)
                report($sformatf("pixel %0d green got %0d want %0d",
                                 want.pix_index, got.green, want.green));
            if (got.blue !== want.blue)
                report($sformatf("pixel %0d blue got %0d want %0d",
                                 want.pix_index, got.blue, want.blue));
            if (got.white !== want.white)
                report($sformatf("pixel %0d white got %0d want %0d",
                                 want.pix_index, got.white, want.white));
            if (got.last_pixel !== want.last_pixel)
                report($sformatf("pixel %0d last_pixel got %0d want %0d",
                                 want.pix_index, got.last_pixel, want.last_pixel));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    bit                    burst_mode;
    bit                    hold_req;
    frame_scoreboard       sb;

    awss_time_if  time_ch ();
    awss_pixel_if pix_ch ();

    amber_white_strobe_sequencer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_time     (time_ch),
        .o_pixel    (pix_ch)
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Watchdog for a hung run.
    initial begin
        #20000000;
        $display("tb_amber_white_strobe_sequencer NOT OK");
        $finish;
    end

    // Pixel receiver: random stalls, one long hold-off on request.
    initial begin : pixel_sink
        int     gap;
        t_pixel got;
        pix_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end else if (burst_mode) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                pix_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pix_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(pix_ch.valid && pix_ch.ready));
            got.pix_index  = pix_ch.pixel_index;
            got.red        = pix_ch.red;
            got.green      = pix_ch.green;
            got.blue       = pix_ch.blue;
            got.white      = pix_ch.white;
            got.last_pixel = pix_ch.last_pixel;
            sb.check_pixel(got);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Writes all four registers; unused upper data bits carry noise.
    task automatic program_regs(logic [15:0] period, logic [6:0] duty,
                                logic [7:0] bright, logic [6:0] leds);
        logic [15:0] noise;
        noise = 16'($urandom);
        write_reg(REG_PERIOD, period);
        write_reg(REG_DUTY, {noise[15:7], duty});
        write_reg(REG_BRIGHTNESS, {noise[15:8], bright});
        write_reg(REG_LED_COUNT, {noise[15:7], leds});
    endtask

    // Offers one time value and records it once the transfer happens.
    task automatic send_time(logic [TIME_W-1:0] now);
        int gap;
        @(negedge i_clk);
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            time_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        time_ch.valid  <= 1'b1;
        time_ch.now_ms <= now;
        do @(posedge i_clk); while (!time_ch.ready);
        sb.note_time(now);
    endtask

    // Stops offering and waits until every owed pixel has arrived.
    task automatic drain();
        int guard;
        guard = 0;
        @(negedge i_clk);
        time_ch.valid <= 1'b0;
        while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Aims most times at the toggle boundary, the rest past it, inside the interval, near the last toggle or anywhere.
    function automatic logic [TIME_W-1:0] pick_time();
        logic [TIME_W-1:0] iv;
        iv = sb.interval_ms();
        case ($urandom_range(0, 9))
            0, 1, 2: return sb.last_toggle + iv - 1;
            3, 4, 5: return sb.last_toggle + iv;
            6:       return sb.last_toggle + iv + $urandom_range(1, 50);
            7:       return sb.last_toggle + $urandom_range(0, iv);
            8:       return $urandom;
            default: return sb.last_toggle + $urandom_range(0, 3);
        endcase
    endfunction

    initial begin : stimulus
        logic [15:0] period;
        logic [6:0]  duty;
        logic [6:0]  leds;
        sb              = new();
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_PERIOD;
        i_cfg_data      = '0;
        time_ch.valid   = 1'b0;
        time_ch.now_ms  = '0;
        burst_mode      = 1'b0;
        hold_req        = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default settings: both sides of the off and on boundaries, then a wrap.
        send_time(32'd0);
        send_time(32'd249);
        send_time(32'd250);
        send_time(32'd499);
        send_time(32'd500);
        send_time(32'hFFFF_FFFF);
        send_time(32'd249);
        drain();

        // Zero interval with an odd strip: every step, both halves swapped.
        program_regs(16'd0, 7'd50, 8'h80, 7'd7);
        repeat (12) send_time($urandom);
        drain();

        // Duty above 100 saturates; a zero LED count means one LED.
        program_regs(16'hFFFF, 7'd127, 8'd0, 7'd0);
        send_time(sb.last_toggle + 32'd65534);
        send_time(sb.last_toggle);
        send_time(sb.last_toggle + 32'd65535);
        drain();

        // Zero duty, oversized LED count clamps to the full strip.
        program_regs(16'hFFFF, 7'd0, 8'd255, 7'd127);
        send_time(sb.last_toggle + 32'd65535);
        send_time(sb.last_toggle);
        send_time(sb.last_toggle + 32'd65534);
        drain();

        // Random phases with a fresh setting each.
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 3))
                0:       period = 16'd0;
                1:       period = 16'hFFFF;
                2:       period = 16'($urandom_range(0, 40));
                default: period = 16'($urandom_range(0, 400));
            endcase
            duty = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(101, 127))
                                               : 7'($urandom_range(0, 100));
            case ($urandom_range(0, 5))
                0:       leds = 7'd0;
                1:       leds = 7'd64;
                2:       leds = 7'($urandom_range(65, 127));
                default: leds = 7'($urandom_range(1, 10));
            endcase
            // Pressure phase: a frame per transfer while the receiver holds off.
            if (ph == 5) begin
                period = 16'd0;
                leds   = 7'd64;
            end
            program_regs(period, duty, 8'($urandom), leds);
            burst_mode = (ph == 3 || ph == 5);
            if (ph == 5) hold_req = 1'b1;
            for (int k = 0; k < 29; k++) begin
                send_time(pick_time());
                // Sender pause until every frame has drained.
                if (ph == 7 && k == 14) drain();
            end
            drain();
        end

        burst_mode = 1'b0;
        repeat (80) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d pixels never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("tb_amber_white_strobe_sequencer OK");
        end else begin
            $display("tb_amber_white_strobe_sequencer NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/awss_pkg.sv
sv/awss_time_if.sv
sv/awss_pixel_if.sv
sv/awss_cfg_regs.sv
sv/awss_ctrl.sv
sv/awss_datapath.sv
sv/amber_white_strobe_sequencer.sv
tb/sv/tb_amber_white_strobe_sequencer.sv
